@@ hdl/tws_pkg.sv @@
// Package for the true wind smoothing unit: payload structs, CORDIC arctangent
// table, sequencer states and unit conversion constants. No dependencies.
package tws_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam logic [8:0] WEIGHT_RESET = 9'd230;
	localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
	localparam logic [16:0] KNOTS_PER_MS_Q16 = 17'd127391;
	// Vector datapath width: holds w*Q30 sums of two unit vectors, and Q8.8 speed times Q30.
	localparam int VW = 50;

	typedef struct packed {
		logic speed_present;
		logic [15:0] water_speed;
		logic wind_present;
		logic [15:0] wind_speed;
		logic signed [15:0] wind_angle;
	} in_item_t;

	typedef struct packed {
		logic [15:0] water_speed_knots;
		logic [15:0] apparent_speed_knots;
		logic signed [15:0] apparent_angle_centideg;
		logic [15:0] true_speed_knots;
		logic signed [15:0] true_angle_centideg;
		logic water_valid;
		logic apparent_valid;
		logic true_valid;
	} out_item_t;

	// CORDIC cell mode and control bundle handed down the row.
	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_ROTATE,
		MODE_VECTOR
	} cordic_mode_t;

	typedef struct packed {
		cordic_mode_t mode;
		logic flip;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROT_OLD,
		ST_ROT_NEW,
		ST_MIX,
		ST_VEC_SMOOTH,
		ST_ROT_TRUE,
		ST_SUB_TRUE,
		ST_VEC_TRUE,
		ST_MAG1,
		ST_MAG2,
		ST_CONV,
		ST_DONE
	} seq_state_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'd536870912;
			1: t = 32'd316933406;
			2: t = 32'd167458907;
			3: t = 32'd85004756;
			4: t = 32'd42667331;
			5: t = 32'd21354465;
			6: t = 32'd10679838;
			7: t = 32'd5340245;
			8: t = 32'd2670163;
			9: t = 32'd1335087;
			10: t = 32'd667544;
			11: t = 32'd333772;
			12: t = 32'd166886;
			13: t = 32'd83443;
			14: t = 32'd41722;
			15: t = 32'd20861;
			16: t = 32'd10430;
			17: t = 32'd5215;
			18: t = 32'd2608;
			19: t = 32'd1304;
			20: t = 32'd652;
			21: t = 32'd326;
			22: t = 32'd163;
			23: t = 32'd81;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

	// Binary angle to centidegrees, -18000..17999.
	function automatic logic signed [15:0] to_centideg(input logic [15:0] b);
		logic [15:0] u;
		logic [31:0] p;
		logic [16:0] r;
		u = b ^ 16'h8000;
		p = 32'(u) * 32'd36000 + 32'd32768;
		r = {1'b0, p[31:16]} - 17'd18000;
		return r[15:0];
	endfunction

	// Q8.8 m/s to saturated Q8.8 knots.
	function automatic logic [15:0] to_knots(input logic [15:0] v);
		logic [33:0] p;
		logic [17:0] k;
		p = 34'(v) * 34'(KNOTS_PER_MS_Q16) + 34'd32768;
		k = p[33:16];
		return (k > 18'd65535) ? 16'hFFFF : k[15:0];
	endfunction

endpackage

@@ hdl/tws_cell.sv @@
// One CORDIC micro-rotation cell with a fixed shift and arctangent constant.
// Depends on tws_pkg.
module tws_cell #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic arst_n,
	input tws_pkg::cell_ctl_t ctl_in,
	input logic signed [tws_pkg::VW-1:0] x_in,
	input logic signed [tws_pkg::VW-1:0] y_in,
	input logic [31:0] z_in,
	output tws_pkg::cell_ctl_t ctl_out,
	output logic signed [tws_pkg::VW-1:0] x_out,
	output logic signed [tws_pkg::VW-1:0] y_out,
	output logic [31:0] z_out
);

	localparam logic [31:0] ATAN_C = tws_pkg::atan_turn(STEP);

	logic up;
	logic signed [tws_pkg::VW-1:0] xs, ys;

	always_comb begin
		xs = x_in >>> STEP;
		ys = y_in >>> STEP;
		if (ctl_in.mode == tws_pkg::MODE_VECTOR) begin
			up = ~y_in[tws_pkg::VW-1];
		end else begin
			up = ~z_in[31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '{mode: tws_pkg::MODE_IDLE, flip: 1'b0};
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.mode == tws_pkg::MODE_VECTOR) begin
			x_out <= up ? x_in + ys : x_in - ys;
			y_out <= up ? y_in - xs : y_in + xs;
			z_out <= up ? z_in + ATAN_C : z_in - ATAN_C;
		end else begin
			x_out <= up ? x_in - ys : x_in + ys;
			y_out <= up ? y_in + xs : y_in - xs;
			z_out <= up ? z_in - ATAN_C : z_in + ATAN_C;
		end
	end

endmodule

@@ hdl/tws_chain.sv @@
// Row of CORDIC cells, one per step, passing the vector along every cycle.
// Depends on tws_pkg and tws_cell.
module tws_chain #(
	parameter int CORDIC_STEPS = tws_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input tws_pkg::cell_ctl_t ctl_in,
	input logic signed [tws_pkg::VW-1:0] x_in,
	input logic signed [tws_pkg::VW-1:0] y_in,
	input logic [31:0] z_in,
	output tws_pkg::cell_ctl_t ctl_out,
	output logic signed [tws_pkg::VW-1:0] x_out,
	output logic signed [tws_pkg::VW-1:0] y_out,
	output logic [31:0] z_out
);

	tws_pkg::cell_ctl_t ctl_w [CORDIC_STEPS+1];
	logic signed [tws_pkg::VW-1:0] x_w [CORDIC_STEPS+1];
	logic signed [tws_pkg::VW-1:0] y_w [CORDIC_STEPS+1];
	logic [31:0] z_w [CORDIC_STEPS+1];

	assign ctl_w[0] = ctl_in;
	assign x_w[0] = x_in;
	assign y_w[0] = y_in;
	assign z_w[0] = z_in;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		tws_cell #(.STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_in(ctl_w[g]), .x_in(x_w[g]), .y_in(y_w[g]), .z_in(z_w[g]),
			.ctl_out(ctl_w[g+1]), .x_out(x_w[g+1]), .y_out(y_w[g+1]),
			.z_out(z_w[g+1])
		);
	end

	assign ctl_out = ctl_w[CORDIC_STEPS];
	assign x_out = x_w[CORDIC_STEPS];
	assign y_out = y_w[CORDIC_STEPS];
	assign z_out = z_w[CORDIC_STEPS];

endmodule

@@ hdl/true_wind_smoothing_unit_top.sv @@
// Top level of the true wind smoothing unit: sequencer, smoothing arithmetic
// and one shared CORDIC cell chain. Depends on tws_pkg and tws_chain.
//
// Usage: an input item is accepted when in_valid is high and in_stall is low.
// It carries an optional water speed sample and an optional apparent wind
// sample. Exactly one result item follows per input item on out_valid, held
// steady until the receiver lowers out_stall.
// The block works on one item at a time. A tick that needs no angle work
// goes from ST_ROT_OLD through ST_ROT_TRUE straight to ST_DONE. A tick with
// a smoothed wind angle and true wind makes five passes through the CORDIC
// cell row (two rotations and a vectoring for the smoothed angle, a rotation
// and a vectoring for true wind), plus six steps of mixing, subtraction,
// scaling and handoff. The block returns to idle before the next item is
// taken.
// While a result waits in the output register, the next item is already
// accepted and processed; it waits only at the final handoff if the previous
// result is still stalled.
// Reset clears the smoothed state, the known flags and the output valid, and
// loads weight_q with 230. The weight register may be written only
// while the block is idle; values above 256 act as 256.
module true_wind_smoothing_unit_top #(
	parameter int CORDIC_STEPS = tws_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [8:0] cfg_wdata,
	input logic in_valid,
	output logic in_stall,
	input tws_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output tws_pkg::out_item_t out_item
);

	localparam int VW = tws_pkg::VW;
	// Depth of the cell row: one register per cell.
	localparam int LAT = CORDIC_STEPS;
	localparam int CW = $clog2(LAT + 2);

	tws_pkg::seq_state_t state_q, state_d;

	logic [8:0] weight_q;
	logic [15:0] sws_q, swd_q, swa_q;
	logic wknown_q, windk_q;

	// Latched item and working registers.
	tws_pkg::in_item_t item_q;
	logic [8:0] w_q;
	logic tv_q;
	logic signed [VW-1:0] co_q, so_q, ax_q, ay_q;
	logic [15:0] ang_q;
	logic signed [VW-1:0] mag_q;
	logic [47:0] t_q;
	logic [CW-1:0] cnt_q;

	tws_pkg::out_item_t res_q;
	logic ov_q;

	// Chain interface.
	tws_pkg::cell_ctl_t c_in, c_out;
	logic signed [VW-1:0] cx_in, cy_in, cx_out, cy_out;
	logic [31:0] cz_in, cz_out;
	logic rot_flip;
	logic [31:0] rot_z;

	// Rotation seed from a 16-bit binary angle, with quadrant fold.
	function automatic logic [32:0] fold(input logic [15:0] a);
		logic [31:0] z;
		z = {a, 16'h0};
		if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
			return {1'b1, z - 32'h8000_0000};
		end
		return {1'b0, z};
	endfunction

	logic [15:0] rot_angle;
	logic vec_start;
	logic signed [VW-1:0] vx, vy;

	always_comb begin
		rot_angle = (state_q == tws_pkg::ST_ROT_OLD) ? swa_q : item_q.wind_angle;
		{rot_flip, rot_z} = fold(rot_angle);
		vx = ax_q;
		vy = ay_q;
		c_in = '{mode: tws_pkg::MODE_IDLE, flip: 1'b0};
		cx_in = VW'(tws_pkg::INV_GAIN_Q30);
		cy_in = '0;
		cz_in = rot_z;
		vec_start = (state_q == tws_pkg::ST_VEC_SMOOTH || state_q == tws_pkg::ST_VEC_TRUE)
			&& cnt_q == '0;
		if ((state_q == tws_pkg::ST_ROT_OLD || state_q == tws_pkg::ST_ROT_NEW
			|| state_q == tws_pkg::ST_ROT_TRUE) && cnt_q == '0) begin
			c_in = '{mode: tws_pkg::MODE_ROTATE, flip: rot_flip};
		end else if (vec_start) begin
			c_in = '{mode: tws_pkg::MODE_VECTOR, flip: vx[VW-1]};
			cx_in = vx[VW-1] ? -vx : vx;
			cy_in = vx[VW-1] ? -vy : vy;
			cz_in = vx[VW-1] ? 32'h8000_0000 : 32'h0;
		end
	end

	tws_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
		.clk(clk), .arst_n(arst_n),
		.ctl_in(c_in), .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
		.ctl_out(c_out), .x_out(cx_out), .y_out(cy_out), .z_out(cz_out)
	);

	logic chain_done;
	assign chain_done = cnt_q == CW'(LAT);

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != tws_pkg::ST_IDLE;

	logic signed [VW-1:0] rx, ry;
	assign rx = c_out.flip ? -cx_out : cx_out;
	assign ry = c_out.flip ? -cy_out : cy_out;

	logic vec_zero;
	assign vec_zero = ax_q == '0 && ay_q == '0;

	logic [31:0] zr;
	assign zr = cz_out + 32'h8000;

	// Smoothing of one 16-bit speed.
	function automatic logic [15:0] smooth(input logic [8:0] w, input logic [15:0] o,
		input logic [15:0] n);
		logic [25:0] s;
		s = 26'(w) * 26'(o) + 26'(9'd256 - w) * 26'(n) + 26'd128;
		return s[23:8];
	endfunction

	function automatic logic [8:0] w_eff(input logic [8:0] w);
		return (w > 9'd256) ? 9'd256 : w;
	endfunction

	logic wind_smooth;
	assign wind_smooth = item_q.wind_present && windk_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tws_pkg::ST_IDLE: begin
				if (accept) state_d = tws_pkg::ST_ROT_OLD;
			end
			tws_pkg::ST_ROT_OLD: begin
				if (!wind_smooth) state_d = tws_pkg::ST_ROT_TRUE;
				else if (chain_done) state_d = tws_pkg::ST_ROT_NEW;
			end
			tws_pkg::ST_ROT_NEW: if (chain_done) state_d = tws_pkg::ST_MIX;
			tws_pkg::ST_MIX: state_d = tws_pkg::ST_VEC_SMOOTH;
			tws_pkg::ST_VEC_SMOOTH: begin
				if (vec_zero || chain_done) state_d = tws_pkg::ST_ROT_TRUE;
			end
			tws_pkg::ST_ROT_TRUE: begin
				if (!tv_q) state_d = tws_pkg::ST_DONE;
				else if (chain_done) state_d = tws_pkg::ST_SUB_TRUE;
			end
			tws_pkg::ST_SUB_TRUE: state_d = tws_pkg::ST_VEC_TRUE;
			tws_pkg::ST_VEC_TRUE: begin
				if (vec_zero || chain_done) state_d = tws_pkg::ST_MAG1;
			end
			tws_pkg::ST_MAG1: state_d = tws_pkg::ST_MAG2;
			tws_pkg::ST_MAG2: state_d = tws_pkg::ST_CONV;
			tws_pkg::ST_CONV: state_d = tws_pkg::ST_DONE;
			tws_pkg::ST_DONE: if (!ov_q || !out_stall) state_d = tws_pkg::ST_IDLE;
			default: state_d = tws_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tws_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Cycle counter for a pass through the row; restarts on each state change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_d != state_q) begin
			cnt_q <= '0;
		end else if (!chain_done) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= tws_pkg::WEIGHT_RESET;
			sws_q <= '0;
			swd_q <= '0;
			swa_q <= '0;
			wknown_q <= 1'b0;
			windk_q <= 1'b0;
			tv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cfg_we) weight_q <= cfg_wdata;
			// A new result replaces the one leaving in the same cycle.
			if (state_q == tws_pkg::ST_DONE && (!ov_q || !out_stall)) ov_q <= 1'b1;
			else if (out_valid && !out_stall) ov_q <= 1'b0;
			if (accept) begin
				// Water speed is settled at once; it feeds the true wind subtraction.
				if (in_item.speed_present) begin
					sws_q <= wknown_q ? smooth(w_eff(weight_q), sws_q, in_item.water_speed)
						: in_item.water_speed;
				end
				wknown_q <= in_item.speed_present;
				tv_q <= in_item.wind_present && in_item.speed_present;
			end
			if (state_q == tws_pkg::ST_ROT_OLD && cnt_q == '0) begin
				if (item_q.wind_present) begin
					if (windk_q) begin
						swd_q <= smooth(w_q, swd_q, item_q.wind_speed);
					end else begin
						swd_q <= item_q.wind_speed;
						swa_q <= item_q.wind_angle;
					end
				end
				windk_q <= item_q.wind_present;
			end
			if (state_q == tws_pkg::ST_VEC_SMOOTH) begin
				if (vec_zero) swa_q <= '0;
				else if (chain_done) swa_q <= zr[31:16];
			end
		end
	end

	// Payload working registers.
	logic [15:0] true_kn;
	always_comb begin
		true_kn = (t_q[47:24] > 24'd65535) ? 16'hFFFF : t_q[39:24];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
			w_q <= w_eff(weight_q);
		end
		if (chain_done && state_q == tws_pkg::ST_ROT_OLD) begin
			co_q <= rx;
			so_q <= ry;
		end
		if (chain_done && state_q == tws_pkg::ST_ROT_NEW) begin
			ax_q <= rx;
			ay_q <= ry;
		end
		if (state_q == tws_pkg::ST_MIX) begin
			ax_q <= VW'(co_q * $signed({1'b0, w_q}))
				+ VW'(ax_q * $signed({1'b0, 9'd256 - w_q}));
			ay_q <= VW'(so_q * $signed({1'b0, w_q}))
				+ VW'(ay_q * $signed({1'b0, 9'd256 - w_q}));
		end
		if (chain_done && state_q == tws_pkg::ST_ROT_TRUE) begin
			ax_q <= VW'(rx * $signed({1'b0, item_q.wind_speed}));
			ay_q <= VW'(ry * $signed({1'b0, item_q.wind_speed}));
		end
		if (state_q == tws_pkg::ST_SUB_TRUE) begin
			ax_q <= ax_q - $signed({2'b0, sws_q, 30'h0});
		end
		if (state_q == tws_pkg::ST_VEC_TRUE) begin
			if (vec_zero) begin
				ang_q <= '0;
				mag_q <= '0;
			end else if (chain_done) begin
				ang_q <= zr[31:16];
				mag_q <= cx_out;
			end
		end
		// The gain product reaches about 2^56, so it is formed at 64 bits.
		if (state_q == tws_pkg::ST_MAG1) begin
			t_q <= 48'((64'(mag_q[VW-1:22]) * 64'(tws_pkg::INV_GAIN_Q30)
				+ 64'd536870912) >> 30);
		end
		if (state_q == tws_pkg::ST_MAG2) begin
			t_q <= 48'(t_q[27:0]) * 48'(tws_pkg::KNOTS_PER_MS_Q16) + 48'd8388608;
		end
		if (state_q == tws_pkg::ST_DONE && (!ov_q || !out_stall)) begin
			res_q.water_valid <= wknown_q;
			res_q.water_speed_knots <= wknown_q ? tws_pkg::to_knots(sws_q) : '0;
			res_q.apparent_valid <= windk_q;
			res_q.apparent_speed_knots <= windk_q ? tws_pkg::to_knots(swd_q) : '0;
			res_q.apparent_angle_centideg <= windk_q ? tws_pkg::to_centideg(swa_q) : '0;
			res_q.true_valid <= tv_q;
			res_q.true_speed_knots <= tv_q ? true_kn : '0;
			res_q.true_angle_centideg <= tv_q ? tws_pkg::to_centideg(ang_q) : '0;
		end
	end

	assign out_valid = ov_q;
	assign out_item = res_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != tws_pkg::ST_IDLE |-> in_stall)
		else $error("item accepted while busy");
	a_true_needs_water: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_q.true_valid |-> res_q.water_valid && res_q.apparent_valid)
		else $error("true wind valid without sources");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_q))
		else $error("result changed while stalled");
	a_row_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tws_pkg::ST_IDLE |-> c_in.mode == tws_pkg::MODE_IDLE)
		else $error("row fed while idle");

endmodule
